[sv/wpp_pkg.sv]
package wpp_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_file;
  } wpp_in_t;

  typedef struct packed {
    logic        is_status;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic [29:0] pair_count;
    logic        last;
  } wpp_out_t;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CHUNK_HDR,
    PH_FMT,
    PH_SKIP,
    PH_DATA,
    PH_DONE
  } wpp_phase_t;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_SHORT_HDR   = 3'd1;
  localparam logic [2:0] ST_NOT_WAVE    = 3'd2;
  localparam logic [2:0] ST_NO_CHUNK    = 3'd3;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd4;
  localparam logic [2:0] ST_EMPTY       = 3'd5;
  localparam logic [2:0] ST_TRUNCATED   = 3'd6;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [5:0]  FMT_READ_MAX = 6'd32;
  localparam logic [31:0] FMT_MIN_LEN  = 32'd16;
  localparam logic [5:0]  HDR_BYTES    = 6'd12;
  localparam logic [5:0]  CHUNK_BYTES  = 6'd8;

  localparam logic [31:0] MAX_DATA_RESET = 32'd8388608;

endpackage

[sv/wpp_fifo.sv]
module wpp_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push0,
  input  wpp_pkg::wpp_out_t push0_data,
  input  logic              push1,
  input  wpp_pkg::wpp_out_t push1_data,
  input  logic              pop,
  output logic              not_empty,
  output logic              room_two,
  output wpp_pkg::wpp_out_t head
);
  import wpp_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] ROOM_LIMIT = CW'(DEPTH - 2);

  wpp_out_t entry_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_inc;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == LAST_PTR) ? '0 : p + AW'(1);
  endfunction

  assign wr_ptr_inc = ptr_inc(wr_ptr_r);
  assign not_empty  = (count_r != '0);
  assign room_two   = (count_r <= ROOM_LIMIT);
  assign head       = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push0 && push1) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_inc);
    end else if (push0) begin
      wr_ptr_nxt = wr_ptr_inc;
    end
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(push0) + CW'(push1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      entry_r[wr_ptr_r] <= push0_data;
    end
    if (push1) begin
      entry_r[wr_ptr_inc] <= push1_data;
    end
  end

endmodule

[sv/wpp_parse.sv]
module wpp_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  wpp_pkg::wpp_in_t  in_data,
  input  logic [31:0]       max_data_bytes,
  output logic              res0_valid,
  output wpp_pkg::wpp_out_t res0,
  output logic              res1_valid,
  output wpp_pkg::wpp_out_t res1
);
  import wpp_pkg::*;

  wpp_phase_t  phase_r, phase_nxt;
  logic [5:0]  field_bytes_r, field_bytes_nxt, fb_inc;
  logic [31:0] chunk_tag_r, chunk_tag_nxt, tag_shift;
  logic [31:0] chunk_length_r, chunk_length_nxt, len_new;
  logic [32:0] skip_left_r, skip_left_nxt, skip_dec;
  logic [15:0] format_code_r, format_code_nxt;
  logic [15:0] channel_count_r, channel_count_nxt;
  logic [15:0] sample_bits_r, sample_bits_nxt;
  logic        format_seen_r, format_seen_nxt;
  logic [31:0] data_left_r, data_left_nxt, left_dec;
  logic [31:0] data_taken_r, data_taken_nxt, taken_inc;
  logic        header_ok_r, header_ok_nxt;
  logic [31:0] want;
  logic [7:0]  b;
  logic        p_v, q_v, e_v;
  wpp_out_t    p, q, e;

  function automatic logic [5:0] fmt_rd(input logic [31:0] len);
    fmt_rd = (len < 32'(FMT_READ_MAX)) ? len[5:0] : FMT_READ_MAX;
  endfunction

  function automatic logic [32:0] fmt_skip(input logic [31:0] len);
    fmt_skip = {1'b0, len - {26'd0, fmt_rd(len)}} + {32'd0, len[0]};
  endfunction

  function automatic wpp_out_t status_word(input logic [2:0] code,
                                           input logic [29:0] pairs);
    wpp_out_t w;
    w.is_status  = 1'b1;
    w.data_byte  = '0;
    w.status     = code;
    w.pair_count = pairs;
    w.last       = 1'b0;
    status_word = w;
  endfunction

  assign b         = in_data.in_byte;
  assign fb_inc    = field_bytes_r + 6'd1;
  assign tag_shift = {chunk_tag_r[23:0], b};
  assign skip_dec  = (skip_left_r != '0) ? skip_left_r - 33'd1 : skip_left_r;
  assign left_dec  = (data_left_r != '0) ? data_left_r - 32'd1 : data_left_r;
  assign taken_inc = data_taken_r + 32'd1;

  always_comb begin
    len_new = chunk_length_r;
    case (field_bytes_r[1:0])
      2'd0:    len_new[7:0]   = chunk_length_r[7:0]   | b;
      2'd1:    len_new[15:8]  = chunk_length_r[15:8]  | b;
      2'd2:    len_new[23:16] = chunk_length_r[23:16] | b;
      default: len_new[31:24] = chunk_length_r[31:24] | b;
    endcase
    want = (len_new < max_data_bytes) ? len_new : max_data_bytes;
    want[0] = 1'b0;
  end

  always_comb begin
    phase_nxt         = phase_r;
    field_bytes_nxt   = field_bytes_r;
    chunk_tag_nxt     = chunk_tag_r;
    chunk_length_nxt  = chunk_length_r;
    skip_left_nxt     = skip_left_r;
    format_code_nxt   = format_code_r;
    channel_count_nxt = channel_count_r;
    sample_bits_nxt   = sample_bits_r;
    format_seen_nxt   = format_seen_r;
    data_left_nxt     = data_left_r;
    data_taken_nxt    = data_taken_r;
    header_ok_nxt     = header_ok_r;
    p_v = 1'b0;
    q_v = 1'b0;
    e_v = 1'b0;
    p   = status_word(ST_OK, '0);
    q   = status_word(ST_OK, '0);
    e   = status_word(ST_OK, '0);

    unique case (phase_r)
      PH_HEADER: begin
        chunk_tag_nxt   = tag_shift;
        field_bytes_nxt = fb_inc;
        if (field_bytes_r == 6'd3) begin
          header_ok_nxt = (tag_shift == TAG_RIFF);
        end
        if (fb_inc >= HDR_BYTES) begin
          if (header_ok_nxt && tag_shift == TAG_WAVE) begin
            phase_nxt        = PH_CHUNK_HDR;
            field_bytes_nxt  = '0;
            chunk_tag_nxt    = '0;
            chunk_length_nxt = '0;
          end else begin
            p_v       = 1'b1;
            p         = status_word(ST_NOT_WAVE, '0);
            phase_nxt = PH_DONE;
          end
        end
      end
      PH_CHUNK_HDR: begin
        field_bytes_nxt = fb_inc;
        if (field_bytes_r < 6'd4) begin
          chunk_tag_nxt = tag_shift;
        end else begin
          chunk_length_nxt = len_new;
        end
        if (fb_inc >= CHUNK_BYTES) begin
          field_bytes_nxt = '0;
          if (chunk_tag_r == TAG_FMT) begin
            phase_nxt = PH_FMT;
            if (len_new == '0) begin
              phase_nxt        = PH_CHUNK_HDR;
              chunk_tag_nxt    = '0;
              chunk_length_nxt = '0;
            end
          end else if (chunk_tag_r == TAG_DATA) begin
            if (!format_seen_r) begin
              p_v       = 1'b1;
              p         = status_word(ST_NO_CHUNK, '0);
              phase_nxt = PH_DONE;
            end else if (!(format_code_r == 16'd1 && channel_count_r == 16'd2 &&
                           sample_bits_r == 16'd16)) begin
              p_v       = 1'b1;
              p         = status_word(ST_UNSUPPORTED, '0);
              phase_nxt = PH_DONE;
            end else if (want == '0) begin
              p_v       = 1'b1;
              p         = status_word(ST_EMPTY, '0);
              phase_nxt = PH_DONE;
            end else begin
              data_left_nxt  = want;
              data_taken_nxt = '0;
              phase_nxt      = PH_DATA;
            end
          end else begin
            skip_left_nxt = {1'b0, len_new} + {32'd0, len_new[0]};
            if (len_new != '0) begin
              phase_nxt = PH_SKIP;
            end else begin
              phase_nxt        = PH_CHUNK_HDR;
              chunk_tag_nxt    = '0;
              chunk_length_nxt = '0;
            end
          end
        end
      end
      PH_FMT: begin
        if (chunk_length_r >= FMT_MIN_LEN) begin
          case (field_bytes_r)
            6'd0:    format_code_nxt[7:0]    = b;
            6'd1:    format_code_nxt[15:8]   = b;
            6'd2:    channel_count_nxt[7:0]  = b;
            6'd3:    channel_count_nxt[15:8] = b;
            6'd14:   sample_bits_nxt[7:0]    = b;
            6'd15:   sample_bits_nxt[15:8]   = b;
            default: ;
          endcase
        end
        field_bytes_nxt = fb_inc;
        if (fb_inc >= fmt_rd(chunk_length_r)) begin
          if (chunk_length_r >= FMT_MIN_LEN) begin
            format_seen_nxt = 1'b1;
          end
          skip_left_nxt = fmt_skip(chunk_length_r);
          if (fmt_skip(chunk_length_r) != '0) begin
            phase_nxt = PH_SKIP;
          end else begin
            phase_nxt        = PH_CHUNK_HDR;
            field_bytes_nxt  = '0;
            chunk_tag_nxt    = '0;
            chunk_length_nxt = '0;
          end
        end
      end
      PH_SKIP: begin
        skip_left_nxt = skip_dec;
        if (skip_dec == '0) begin
          phase_nxt        = PH_CHUNK_HDR;
          field_bytes_nxt  = '0;
          chunk_tag_nxt    = '0;
          chunk_length_nxt = '0;
        end
      end
      PH_DATA: begin
        p_v            = 1'b1;
        p              = status_word(ST_OK, '0);
        p.is_status    = 1'b0;
        p.data_byte    = b;
        data_taken_nxt = taken_inc;
        data_left_nxt  = left_dec;
        if (left_dec == '0) begin
          q_v       = 1'b1;
          q         = status_word(ST_OK, taken_inc[31:2]);
          phase_nxt = PH_DONE;
        end
      end
      default: ;
    endcase

    if (in_data.end_of_file) begin
      unique case (phase_nxt)
        PH_HEADER, PH_FMT: begin
          e_v = 1'b1;
          e   = status_word(ST_SHORT_HDR, '0);
        end
        PH_CHUNK_HDR, PH_SKIP: begin
          e_v = 1'b1;
          e   = status_word(ST_NO_CHUNK, '0);
        end
        PH_DATA: begin
          e_v = 1'b1;
          e   = status_word(ST_TRUNCATED, '0);
        end
        default: ;
      endcase
      phase_nxt         = PH_HEADER;
      field_bytes_nxt   = '0;
      chunk_tag_nxt     = '0;
      chunk_length_nxt  = '0;
      skip_left_nxt     = '0;
      format_code_nxt   = '0;
      channel_count_nxt = '0;
      sample_bits_nxt   = '0;
      format_seen_nxt   = 1'b0;
      data_left_nxt     = '0;
      data_taken_nxt    = '0;
      header_ok_nxt     = 1'b0;
    end
  end

  // A status word that ends the data never meets an end-of-file status,
  // so at most two words leave for one byte.
  always_comb begin
    res0_valid = p_v;
    res0       = p;
    res1_valid = q_v;
    res1       = q;
    if (e_v) begin
      if (!p_v) begin
        res0_valid = 1'b1;
        res0       = e;
      end else begin
        res1_valid = 1'b1;
        res1       = e;
      end
    end
    if (res1_valid) begin
      res1.last = 1'b1;
    end else begin
      res0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_HEADER;
      field_bytes_r   <= '0;
      chunk_tag_r     <= '0;
      chunk_length_r  <= '0;
      skip_left_r     <= '0;
      format_code_r   <= '0;
      channel_count_r <= '0;
      sample_bits_r   <= '0;
      format_seen_r   <= 1'b0;
      data_left_r     <= '0;
      data_taken_r    <= '0;
      header_ok_r     <= 1'b0;
    end else if (accept) begin
      phase_r         <= phase_nxt;
      field_bytes_r   <= field_bytes_nxt;
      chunk_tag_r     <= chunk_tag_nxt;
      chunk_length_r  <= chunk_length_nxt;
      skip_left_r     <= skip_left_nxt;
      format_code_r   <= format_code_nxt;
      channel_count_r <= channel_count_nxt;
      sample_bits_r   <= sample_bits_nxt;
      format_seen_r   <= format_seen_nxt;
      data_left_r     <= data_left_nxt;
      data_taken_r    <= data_taken_nxt;
      header_ok_r     <= header_ok_nxt;
    end
  end

endmodule

[sv/wav_pcm_header_parser.sv]
// Words caused by an accepted byte are registered in the output queue before they are offered.
// Throughput: one byte per cycle while in_stall is low; the output queue drains one word per
// cycle while out_stall is low, so a byte that ends the data leaves two words to drain.
// Input stalls while the output queue has fewer than two free entries.
// Reset is synchronous and active low: it clears the parse state and the queue, and
// sets the data byte cap to 8388608.
module wav_pcm_header_parser #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  wpp_pkg::wpp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output wpp_pkg::wpp_out_t out_data,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data
);
  import wpp_pkg::*;

  logic [31:0] max_data_bytes_r;
  logic        accept;
  logic        room_two;
  logic        res0_valid, res1_valid;
  wpp_out_t    res0, res1;

  assign in_stall = !room_two;
  assign accept   = in_valid && room_two;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_data_bytes_r <= MAX_DATA_RESET;
    end else if (cfg_wr_en) begin
      max_data_bytes_r <= cfg_wr_data;
    end
  end

  wpp_parse u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .in_data        (in_data),
    .max_data_bytes (max_data_bytes_r),
    .res0_valid     (res0_valid),
    .res0           (res0),
    .res1_valid     (res1_valid),
    .res1           (res1)
  );

  wpp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push0      (accept && res0_valid),
    .push0_data (res0),
    .push1      (accept && res1_valid),
    .push1_data (res1),
    .pop        (out_valid && !out_stall),
    .not_empty  (out_valid),
    .room_two   (room_two),
    .head       (out_data)
  );

endmodule

[sv/wpp_checker.sv]
module wpp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input wpp_pkg::wpp_out_t out_data
);
  import wpp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_status |-> out_data.last)
    else $error("status word without last");

  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_status |-> out_data.status == ST_OK &&
      out_data.pair_count == '0)
    else $error("data word carries status fields");

  a_pairs_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.pair_count == '0 &&
      out_data.data_byte == '0)
    else $error("error status carries data");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("queue not empty after reset");

endmodule

bind wav_pcm_header_parser wpp_checker u_wpp_checker (.*);

[tb/sv/wav_pcm_header_parser_tb.sv]
module wav_pcm_header_parser_tb;
  import wpp_pkg::*;

  localparam logic [2:0]  NO_STATUS   = 3'd7;
  localparam logic [15:0] PCM_CODE    = 16'd1;
  localparam logic [15:0] STEREO      = 16'd2;
  localparam logic [15:0] PCM_BITS    = 16'd16;
  localparam logic [31:0] TAG_LIST    = 32'h4C49_5354;
  localparam int          BODY_MAX    = 48;
  localparam int          SETTLE      = 4;
  localparam int          HOLD_CYCLES = 200;
  localparam int          RANDOM_BYTES = 600;
  localparam int          NUM_PHASES  = 5;
  localparam int          CAP_EVERY   = 100;
  localparam longint      TIMEOUT_T   = 5_000_000;

  typedef struct packed {
    logic        wr_cap;
    logic [31:0] cap;
    logic [1:0]  hdr_fault;
    logic        has_pre;
    logic [31:0] pre_tag;
    logic [31:0] pre_len;
    logic        has_fmt;
    logic [31:0] fmt_len;
    logic [15:0] fmt_code;
    logic [15:0] chans;
    logic [15:0] bits;
    logic        has_post;
    logic [31:0] post_tag;
    logic [31:0] post_len;
    logic [31:0] data_len;
    logic [15:0] data_sent;
    logic [15:0] trail;
    logic [15:0] cut;
    logic [2:0]  table_status;
  } file_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  wpp_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  wpp_out_t    out_data;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  logic [2:0]  in_table_status;
  int          tx_pct;
  int          rx_pct;
  bit          hold_req;
  int          fail_cnt;
  int          sent_bytes;

  logic [7:0]  file_bytes[$];
  file_row_t   dir_rows[$];
  wpp_out_t    pending_words[$];

  // Parser state as predicted from the bytes accepted so far.
  wpp_phase_t  parse_ph;
  logic [31:0] byte_idx;
  logic [31:0] tag_shift;
  logic [31:0] chunk_len;
  logic [32:0] skip_cnt;
  logic [15:0] seen_code;
  logic [15:0] seen_chans;
  logic [15:0] seen_bits;
  logic        fmt_seen;
  logic [31:0] data_left;
  logic [31:0] data_taken;
  logic        riff_ok;
  logic [31:0] byte_cap;

  wav_pcm_header_parser u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_T);
    $display("wav_pcm_header_parser_tb failed");
    $finish;
  end

  function automatic void clear_parse();
    parse_ph   = PH_HEADER;
    byte_idx   = '0;
    tag_shift  = '0;
    chunk_len  = '0;
    skip_cnt   = '0;
    seen_code  = '0;
    seen_chans = '0;
    seen_bits  = '0;
    fmt_seen   = 1'b0;
    data_left  = '0;
    data_taken = '0;
    riff_ok    = 1'b0;
  endfunction

  function automatic void open_chunk_hdr();
    parse_ph  = PH_CHUNK_HDR;
    byte_idx  = '0;
    tag_shift = '0;
    chunk_len = '0;
  endfunction

  function automatic logic [31:0] fmt_span();
    return (chunk_len < 32'(FMT_READ_MAX)) ? chunk_len : 32'(FMT_READ_MAX);
  endfunction

  function automatic void close_fmt();
    if (chunk_len >= FMT_MIN_LEN) fmt_seen = 1'b1;
    skip_cnt = {1'b0, chunk_len - fmt_span()} + chunk_len[0];
    if (skip_cnt != 0) parse_ph = PH_SKIP;
    else open_chunk_hdr();
  endfunction

  function automatic wpp_out_t status_word(input logic [2:0] st, input logic [29:0] pairs);
    wpp_out_t w;
    w = '0;
    w.is_status  = 1'b1;
    w.status     = st;
    w.pair_count = pairs;
    return w;
  endfunction

  // Predicts the words caused by one accepted byte and queues them.
  task automatic parse_byte(input logic [7:0] b, input logic eof, input logic [2:0] tbl_st);
    wpp_out_t    words[2];
    int          n;
    logic [31:0] want;
    logic [2:0]  st;
    logic        st_on;
    n = 0;
    case (parse_ph)
      PH_HEADER: begin
        tag_shift = {tag_shift[23:0], b};
        if (byte_idx == 3) riff_ok = (tag_shift == TAG_RIFF);
        byte_idx++;
        if (byte_idx >= 32'(HDR_BYTES)) begin
          if (riff_ok && tag_shift == TAG_WAVE) begin
            open_chunk_hdr();
          end else begin
            words[n] = status_word(ST_NOT_WAVE, '0);
            n++;
            parse_ph = PH_DONE;
          end
        end
      end
      PH_CHUNK_HDR: begin
        if (byte_idx < 4) tag_shift = {tag_shift[23:0], b};
        else chunk_len = chunk_len | (32'(b) << (8 * byte_idx[1:0]));
        byte_idx++;
        if (byte_idx >= 32'(CHUNK_BYTES)) begin
          byte_idx = '0;
          if (tag_shift == TAG_FMT) begin
            parse_ph = PH_FMT;
            if (fmt_span() == 0) close_fmt();
          end else if (tag_shift == TAG_DATA) begin
            if (!fmt_seen) begin
              words[n] = status_word(ST_NO_CHUNK, '0);
              n++;
              parse_ph = PH_DONE;
            end else if (!(seen_code == PCM_CODE && seen_chans == STEREO &&
                           seen_bits == PCM_BITS)) begin
              words[n] = status_word(ST_UNSUPPORTED, '0);
              n++;
              parse_ph = PH_DONE;
            end else begin
              want = (chunk_len < byte_cap) ? chunk_len : byte_cap;
              want[0] = 1'b0;
              if (want == 0) begin
                words[n] = status_word(ST_EMPTY, '0);
                n++;
                parse_ph = PH_DONE;
              end else begin
                data_left  = want;
                data_taken = '0;
                parse_ph   = PH_DATA;
              end
            end
          end else begin
            skip_cnt = {1'b0, chunk_len} + chunk_len[0];
            if (skip_cnt != 0) parse_ph = PH_SKIP;
            else open_chunk_hdr();
          end
        end
      end
      PH_FMT: begin
        if (chunk_len >= FMT_MIN_LEN) begin
          case (byte_idx)
            0:  seen_code[7:0]   = b;
            1:  seen_code[15:8]  = b;
            2:  seen_chans[7:0]  = b;
            3:  seen_chans[15:8] = b;
            14: seen_bits[7:0]   = b;
            15: seen_bits[15:8]  = b;
            default: ;
          endcase
        end
        byte_idx++;
        if (byte_idx >= fmt_span()) close_fmt();
      end
      PH_SKIP: begin
        if (skip_cnt != 0) skip_cnt--;
        if (skip_cnt == 0) open_chunk_hdr();
      end
      PH_DATA: begin
        words[n] = '0;
        words[n].data_byte = b;
        n++;
        data_taken++;
        if (data_left != 0) data_left--;
        if (data_left == 0) begin
          words[n] = status_word(ST_OK, data_taken[31:2]);
          n++;
          parse_ph = PH_DONE;
        end
      end
      default: ;
    endcase
    if (eof) begin
      st_on = 1'b1;
      st    = ST_OK;
      case (parse_ph)
        PH_HEADER, PH_FMT:     st = ST_SHORT_HDR;
        PH_CHUNK_HDR, PH_SKIP: st = ST_NO_CHUNK;
        PH_DATA:               st = ST_TRUNCATED;
        default:               st_on = 1'b0;
      endcase
      if (st_on) begin
        words[n] = status_word(st, '0);
        n++;
      end
      clear_parse();
    end
    // Files with a status typed into the table yield that one status word.
    if (n > 0 && tbl_st != NO_STATUS) begin
      words[0] = status_word(tbl_st, '0);
      n = 1;
    end
    if (n > 0) words[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_words.push_back(words[i]);
  endtask

  function automatic bit word_differs(input wpp_out_t a, input wpp_out_t b);
    return (a.is_status !== b.is_status) || (a.data_byte !== b.data_byte) ||
           (a.status !== b.status) || (a.pair_count !== b.pair_count) ||
           (a.last !== b.last);
  endfunction

  task automatic report_word(input string why, input wpp_out_t want, input wpp_out_t got);
    fail_cnt++;
    if (fail_cnt <= 10) begin
      $display("%0t %s: expected is_status=%0d byte=%h status=%0d pairs=%0d last=%0d",
               $time, why, want.is_status, want.data_byte, want.status,
               want.pair_count, want.last);
      $display("%0t %s: got      is_status=%0d byte=%h status=%0d pairs=%0d last=%0d",
               $time, why, got.is_status, got.data_byte, got.status,
               got.pair_count, got.last);
    end
  endtask

  always @(posedge clk) begin
    wpp_out_t want;
    if (rst_n) begin
      if (cfg_wr_en) byte_cap = cfg_wr_data;
      if (in_valid && !in_stall) begin
        parse_byte(in_data.in_byte, in_data.end_of_file, in_table_status);
      end
      if (out_valid && !out_stall) begin
        if (pending_words.size() == 0) begin
          report_word("unexpected word", '0, out_data);
        end else begin
          want = pending_words.pop_front();
          if (word_differs(want, out_data)) report_word("mismatch", want, out_data);
        end
      end
    end
  end

  // The receiver stalls at random, or holds off for a long stretch on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= (rx_pct != 0) && ($urandom_range(99) < rx_pct);
    end
  end

  function automatic void put_tag(input logic [31:0] t);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(t[8*i +: 8]);
  endfunction

  function automatic void put_le32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) file_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic int body_size(input logic [31:0] len);
    return (len > BODY_MAX) ? BODY_MAX : int'(len) + int'(len[0]);
  endfunction

  function automatic void put_chunk(input logic [31:0] tag, input logic [31:0] len);
    int body;
    body = body_size(len);
    put_tag(tag);
    put_le32(len);
    for (int i = 0; i < body; i++) file_bytes.push_back(8'($urandom));
  endfunction

  function automatic void put_fmt(input file_row_t r);
    int         body;
    logic [7:0] b;
    body = body_size(r.fmt_len);
    put_tag(TAG_FMT);
    put_le32(r.fmt_len);
    for (int i = 0; i < body; i++) begin
      b = 8'($urandom);
      case (i)
        0:  b = r.fmt_code[7:0];
        1:  b = r.fmt_code[15:8];
        2:  b = r.chans[7:0];
        3:  b = r.chans[15:8];
        14: b = r.bits[7:0];
        15: b = r.bits[15:8];
        default: ;
      endcase
      file_bytes.push_back(b);
    end
  endfunction

  function automatic void build_file(input file_row_t r);
    file_bytes.delete();
    put_tag((r.hdr_fault == 2'd1) ? (TAG_RIFF ^ 32'h1) : TAG_RIFF);
    put_le32($urandom);
    put_tag((r.hdr_fault == 2'd2) ? (TAG_WAVE ^ 32'h100) : TAG_WAVE);
    if (r.has_pre) put_chunk(r.pre_tag, r.pre_len);
    if (r.has_fmt) put_fmt(r);
    if (r.has_post) put_chunk(r.post_tag, r.post_len);
    put_tag(TAG_DATA);
    put_le32(r.data_len);
    for (int i = 0; i < int'(r.data_sent) + int'(r.trail); i++) begin
      file_bytes.push_back(8'($urandom));
    end
    if (r.cut != 0) begin
      while (file_bytes.size() > int'(r.cut)) void'(file_bytes.pop_back());
    end
  endfunction

  function automatic file_row_t good_row();
    file_row_t r;
    r = '0;
    r.has_fmt      = 1'b1;
    r.fmt_len      = FMT_MIN_LEN;
    r.fmt_code     = PCM_CODE;
    r.chans        = STEREO;
    r.bits         = PCM_BITS;
    r.pre_tag      = TAG_LIST;
    r.post_tag     = TAG_LIST;
    r.data_len     = 32'd8;
    r.data_sent    = 16'd8;
    r.table_status = NO_STATUS;
    return r;
  endfunction

  function automatic logic [31:0] pick_tag();
    case ($urandom_range(3))
      0: return TAG_FMT;
      1: return TAG_DATA;
      default: return $urandom;
    endcase
  endfunction

  function automatic file_row_t random_row();
    file_row_t r;
    r = good_row();
    if ($urandom_range(15) == 0) r.hdr_fault = 2'($urandom_range(1, 2));
    if ($urandom_range(3) == 0) begin
      r.has_pre = 1'b1;
      r.pre_tag = pick_tag();
      r.pre_len = $urandom_range(0, 20);
    end
    if ($urandom_range(15) == 0) begin
      r.has_fmt = 1'b0;
    end else begin
      case ($urandom_range(7))
        0: r.fmt_len = $urandom_range(0, 15);
        1: r.fmt_len = $urandom_range(17, BODY_MAX);
        default: ;
      endcase
      if ($urandom_range(7) == 0) r.fmt_code = ($urandom_range(1) != 0) ? 16'd3 : 16'($urandom);
      if ($urandom_range(7) == 0) r.chans = ($urandom_range(1) != 0) ? 16'd1 : 16'($urandom);
      if ($urandom_range(7) == 0) r.bits = ($urandom_range(1) != 0) ? 16'd24 : 16'($urandom);
    end
    if ($urandom_range(7) == 0) begin
      r.has_post = 1'b1;
      r.post_tag = pick_tag();
      r.post_len = $urandom_range(0, 20);
    end
    case ($urandom_range(7))
      0: r.data_len = $urandom;
      1: r.data_len = $urandom_range(0, 3);
      default: r.data_len = $urandom_range(4, 40);
    endcase
    if (r.data_len < 64 && $urandom_range(3) != 0) r.data_sent = r.data_len[15:0];
    else r.data_sent = 16'($urandom_range(0, 40));
    if ($urandom_range(3) == 0) r.trail = 16'($urandom_range(1, 6));
    if ($urandom_range(7) == 0) r.cut = 16'($urandom_range(1, 60));
    return r;
  endfunction

  function automatic logic [31:0] pick_cap();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'd3;
      3: return 32'hFFFF_FFFF;
      4: return MAX_DATA_RESET;
      default: return $urandom_range(4, 48);
    endcase
  endfunction

  function automatic void build_directed();
    file_row_t r;
    r = good_row();
    dir_rows.push_back(r);
    r = good_row(); r.cut = 16'd3;  r.table_status = ST_SHORT_HDR; dir_rows.push_back(r);
    // A bad tag is only seen once all twelve header bytes are in.
    r = good_row(); r.hdr_fault = 2'd1; r.cut = 16'd11;
    r.table_status = ST_SHORT_HDR; dir_rows.push_back(r);
    r = good_row(); r.hdr_fault = 2'd1; r.trail = 16'd4;
    r.table_status = ST_NOT_WAVE; dir_rows.push_back(r);
    r = good_row(); r.hdr_fault = 2'd2; r.table_status = ST_NOT_WAVE; dir_rows.push_back(r);
    r = good_row(); r.cut = 16'd12; r.table_status = ST_NO_CHUNK; dir_rows.push_back(r);
    r = good_row(); r.cut = 16'd15; r.table_status = ST_NO_CHUNK; dir_rows.push_back(r);
    r = good_row(); r.cut = 16'd25; r.table_status = ST_SHORT_HDR; dir_rows.push_back(r);
    r = good_row(); r.has_fmt = 1'b0; r.table_status = ST_NO_CHUNK; dir_rows.push_back(r);
    r = good_row(); r.fmt_len = 32'd14; r.table_status = ST_NO_CHUNK; dir_rows.push_back(r);
    r = good_row(); r.fmt_code = 16'd3; r.table_status = ST_UNSUPPORTED; dir_rows.push_back(r);
    r = good_row(); r.chans = 16'd1; r.table_status = ST_UNSUPPORTED; dir_rows.push_back(r);
    r = good_row(); r.bits = 16'd24; r.table_status = ST_UNSUPPORTED; dir_rows.push_back(r);
    r = good_row(); r.data_len = 32'd1; r.data_sent = 16'd1;
    r.table_status = ST_EMPTY; dir_rows.push_back(r);
    r = good_row(); r.wr_cap = 1'b1; r.cap = 32'd0;
    r.table_status = ST_EMPTY; dir_rows.push_back(r);
    r = good_row(); r.wr_cap = 1'b1; r.cap = 32'd1;
    r.table_status = ST_EMPTY; dir_rows.push_back(r);
    r = good_row(); r.wr_cap = 1'b1; r.cap = 32'hFFFF_FFFF; r.has_pre = 1'b1;
    r.pre_len = 32'hFFFF_FFFF; r.cut = 16'd40; r.table_status = ST_NO_CHUNK;
    dir_rows.push_back(r);
    r = good_row(); r.data_len = 32'hFFFF_FFFF; r.data_sent = 16'd20; dir_rows.push_back(r);
    r = good_row(); r.fmt_len = 32'd40; r.has_pre = 1'b1; r.pre_len = 32'd3;
    r.data_len = 32'd11; r.data_sent = 16'd11; r.trail = 16'd3; dir_rows.push_back(r);
    r = good_row(); r.wr_cap = 1'b1; r.cap = 32'd5; r.fmt_len = 32'd17;
    r.data_len = 32'd6; r.data_sent = 16'd6; r.trail = 16'd2; dir_rows.push_back(r);
    // A full-size fmt chunk is overwritten by a later one, a short one changes nothing.
    r = good_row(); r.wr_cap = 1'b1; r.cap = MAX_DATA_RESET; r.has_pre = 1'b1;
    r.pre_tag = TAG_FMT; r.pre_len = 32'd16; r.has_post = 1'b1;
    r.post_tag = TAG_FMT; r.post_len = 32'd8; dir_rows.push_back(r);
    r = good_row(); r.has_pre = 1'b1; r.pre_tag = TAG_FMT; r.pre_len = 32'd0;
    dir_rows.push_back(r);
    r = good_row(); r.data_sent = 16'd3; dir_rows.push_back(r);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eof, input logic [2:0] tbl_st);
    int gap;
    gap = 0;
    while (tx_pct != 0 && $urandom_range(99) < tx_pct && gap < 20) gap++;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid                <= 1'b1;
    in_data                 <= {b, eof};
    in_table_status         <= tbl_st;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_file(input file_row_t r);
    build_file(r);
    for (int i = 0; i < file_bytes.size(); i++) begin
      send_byte(file_bytes[i], i == file_bytes.size() - 1, r.table_status);
    end
    sent_bytes += file_bytes.size();
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_cap(input logic [31:0] v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    int budget;
    int next_cap;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    in_table_status = NO_STATUS;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    tx_pct          = 0;
    rx_pct          = 0;
    hold_req        = 1'b0;
    fail_cnt        = 0;
    sent_bytes      = 0;
    clear_parse();
    byte_cap = MAX_DATA_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    build_directed();
    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr_cap) write_cap(dir_rows[i].cap);
      send_file(dir_rows[i]);
      wait_idle();
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        1:       begin tx_pct = 56; rx_pct = 0;  end
        2:       begin tx_pct = 0;  rx_pct = 56; end
        3:       begin tx_pct = 23; rx_pct = 23; end
        default: begin tx_pct = 0;  rx_pct = 0;  end
      endcase
      budget   = sent_bytes + RANDOM_BYTES / NUM_PHASES;
      next_cap = sent_bytes;
      // The last phase opens with a long receiver hold-off so the input backs up.
      if (p == NUM_PHASES - 1) begin
        write_cap(MAX_DATA_RESET);
        hold_req = 1'b1;
        send_file(good_row());
        next_cap = sent_bytes + CAP_EVERY;
      end
      while (sent_bytes < budget) begin
        if (sent_bytes >= next_cap) begin
          write_cap(pick_cap());
          next_cap = sent_bytes + CAP_EVERY;
        end
        send_file(random_row());
        if ($urandom_range(15) == 0) wait_idle();
      end
    end

    wait_idle();
    if (fail_cnt == 0 && pending_words.size() == 0) begin
      $display("wav_pcm_header_parser_tb passed");
    end else begin
      $display("wav_pcm_header_parser_tb failed");
    end
    $finish;
  end

endmodule
